/* hw/rtl/bbtc_pkg.sv */
// ----------------------------------------------------------------------------
// bbtc_pkg
// shared types, command codes and microcode encoding of the transport clock
// ----------------------------------------------------------------------------
`default_nettype none

package bbtc_pkg;

  // command codes carried in the input tuser
  localparam logic [2:0] CMD_ADVANCE = 3'd0;
  localparam logic [2:0] CMD_PLAY    = 3'd1;
  localparam logic [2:0] CMD_PAUSE   = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_REWIND  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BEAT_LENGTH       = 2'd0;
  localparam logic [1:0] REG_BEATS_PER_BAR     = 2'd1;
  localparam logic [1:0] REG_BEATS_PER_QUANTUM = 2'd2;

  // reset values of the configuration registers
  localparam logic [20:0] BEAT_LENGTH_RST       = 21'd22050;
  localparam logic [4:0]  BEATS_PER_BAR_RST     = 5'd4;
  localparam logic [6:0]  BEATS_PER_QUANTUM_RST = 7'd4;

  // divider loop lengths
  localparam logic [5:0] DIV_SUM_STEPS  = 6'd22;
  localparam logic [5:0] DIV_WORD_STEPS = 6'd32;

  // datapath operations
  localparam logic [3:0] OP_ACCEPT   = 4'd0;
  localparam logic [3:0] OP_CMD      = 4'd1;
  localparam logic [3:0] OP_DIV_STEP = 4'd2;
  localparam logic [3:0] OP_BEAT_UPD = 4'd3;
  localparam logic [3:0] OP_LOAD_BAR = 4'd4;
  localparam logic [3:0] OP_BAR_UPD  = 4'd5;
  localparam logic [3:0] OP_LOAD_Q   = 4'd6;
  localparam logic [3:0] OP_Q_UPD    = 4'd7;
  localparam logic [3:0] OP_MUL_LO   = 4'd8;
  localparam logic [3:0] OP_MUL_HI   = 4'd9;
  localparam logic [3:0] OP_ACC      = 4'd10;
  localparam logic [3:0] OP_EMIT     = 4'd11;

  // jump conditions
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_NO_INPUT = 3'd1;
  localparam logic [2:0] COND_NOT_ADV  = 3'd2;
  localparam logic [2:0] COND_DIV_MORE = 3'd3;
  localparam logic [2:0] COND_OUT_FULL = 3'd4;

  // program addresses
  localparam logic [3:0] ADDR_WAIT     = 4'd0;
  localparam logic [3:0] ADDR_CMD      = 4'd1;
  localparam logic [3:0] ADDR_DIV_SUM  = 4'd2;
  localparam logic [3:0] ADDR_BEAT_UPD = 4'd3;
  localparam logic [3:0] ADDR_LOAD_BAR = 4'd4;
  localparam logic [3:0] ADDR_DIV_BAR  = 4'd5;
  localparam logic [3:0] ADDR_BAR_UPD  = 4'd6;
  localparam logic [3:0] ADDR_LOAD_Q   = 4'd7;
  localparam logic [3:0] ADDR_DIV_Q    = 4'd8;
  localparam logic [3:0] ADDR_Q_UPD    = 4'd9;
  localparam logic [3:0] ADDR_MUL_LO   = 4'd10;
  localparam logic [3:0] ADDR_MUL_HI   = 4'd11;
  localparam logic [3:0] ADDR_ACC      = 4'd12;
  localparam logic [3:0] ADDR_EMIT     = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
    logic       last;
  } ctl_word_t;

  // datapath flags tested by the sequencer
  typedef struct packed {
    logic adv_go;
    logic div_more;
    logic out_full;
  } dp_status_t;

  // result transaction, lowest field last
  typedef struct packed {
    logic [52:0] next_quantized_sample;
    logic        is_playing;
    logic [20:0] beat_phase;
    logic [31:0] bar_now;
    logic [31:0] beat_now;
    logic        bar_started;
    logic        beat_changed;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/beat_bar_transport_clock_top.sv */
// ----------------------------------------------------------------------------
// beat_bar_transport_clock_top
// beat and bar transport clock for an audio engine
// ----------------------------------------------------------------------------
// Each input transaction is one transport command (advance, play, pause, stop,
// rewind) and yields exactly one result transaction with the beat and bar
// index, the phase within the beat, the play state, beat-change and bar-start
// flags and the sample time of the next quantization boundary. Commands are
// handled one at a time by a microcoded sequencer driving a shared restoring
// divider (one quotient bit per cycle) and a 17x21 multiplier used twice. An
// advance while playing first runs 22 divider steps to split the new phase
// into whole beats; every command then runs 32 steps each to divide the beat
// counter by beats-per-bar and by beats-per-quantum. A finished result waits
// in the output register, so the next command is accepted while it is still
// pending. Configuration must be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the user is bound by this, as the block itself
// does not enforce it. Writing the beat length restarts the timeline at
// position zero. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module beat_bar_transport_clock_top (
  input  wire logic          clk,
  input  wire logic          rst,
  // command stream
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [15:0]   s_tdata,   // [15:0] sample_count
  input  wire logic [2:0]    s_tuser,   // [2:0] command
  // result stream
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // [0] beat_changed, [1] bar_started, [33:2] beat_now, [65:34] bar_now,
  // [86:66] beat_phase, [87] is_playing, [140:88] next_quantized_sample,
  // [143:141] zero
  output logic [143:0]       m_tdata,
  // configuration writes
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [20:0]   cfg_data
);

  // configuration registers
  logic [20:0] beat_length;
  logic [4:0]  beats_per_bar;
  logic [6:0]  beats_per_quantum;

  // effective values after clamping
  logic [20:0] len_eff;
  logic [4:0]  bar_eff;
  logic [6:0]  q_eff;
  logic        pos_clear;

  bbtc_pkg::ctl_word_t  ctl;
  bbtc_pkg::dp_status_t status;
  bbtc_pkg::result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_length       <= bbtc_pkg::BEAT_LENGTH_RST;
      beats_per_bar     <= bbtc_pkg::BEATS_PER_BAR_RST;
      beats_per_quantum <= bbtc_pkg::BEATS_PER_QUANTUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bbtc_pkg::REG_BEAT_LENGTH:       beat_length       <= cfg_data;
        bbtc_pkg::REG_BEATS_PER_BAR:     beats_per_bar     <= cfg_data[4:0];
        bbtc_pkg::REG_BEATS_PER_QUANTUM: beats_per_quantum <= cfg_data[6:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // a tempo change restarts the timeline
  assign pos_clear = cfg_we && (cfg_index == bbtc_pkg::REG_BEAT_LENGTH);

  // zero means one, oversize saturates
  always_comb begin
    len_eff = (beat_length == '0) ? 21'd1 : beat_length;

    if (beats_per_bar == '0) begin
      bar_eff = 5'd1;
    end else if (beats_per_bar > 5'd16) begin
      bar_eff = 5'd16;
    end else begin
      bar_eff = beats_per_bar;
    end

    if (beats_per_quantum == '0) begin
      q_eff = 7'd1;
    end else if (beats_per_quantum > 7'd64) begin
      q_eff = 7'd64;
    end else begin
      q_eff = beats_per_quantum;
    end
  end

  // the wait step is the only one that takes a command, never during reset
  assign s_tready = !rst && (ctl.op == bbtc_pkg::OP_ACCEPT);

  bbtc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .ctl      (ctl)
  );

  bbtc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .in_valid        (s_tvalid),
    .in_command      (s_tuser),
    .in_sample_count (s_tdata),
    .pos_clear       (pos_clear),
    .len_eff         (len_eff),
    .bar_eff         (bar_eff),
    .q_eff           (q_eff),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_result      (result),
    .status          (status)
  );

  assign m_tdata = {3'd0, result};

endmodule

`default_nettype wire

/* hw/rtl/bbtc_ucode_rom.sv */
// ----------------------------------------------------------------------------
// bbtc_ucode_rom
// control store of the transport clock sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module bbtc_ucode_rom (
  input  wire logic [3:0]          addr,
  output bbtc_pkg::ctl_word_t      word
);

  always_comb begin
    word = '{op: bbtc_pkg::OP_ACCEPT, cond: bbtc_pkg::COND_NONE,
             target: bbtc_pkg::ADDR_WAIT, last: 1'b1};
    unique case (addr)
      bbtc_pkg::ADDR_WAIT: begin
        word = '{bbtc_pkg::OP_ACCEPT, bbtc_pkg::COND_NO_INPUT, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_CMD: begin
        // skip the phase division unless advancing while playing
        word = '{bbtc_pkg::OP_CMD, bbtc_pkg::COND_NOT_ADV, bbtc_pkg::ADDR_LOAD_BAR, 1'b0};
      end
      bbtc_pkg::ADDR_DIV_SUM: begin
        word = '{bbtc_pkg::OP_DIV_STEP, bbtc_pkg::COND_DIV_MORE, bbtc_pkg::ADDR_DIV_SUM, 1'b0};
      end
      bbtc_pkg::ADDR_BEAT_UPD: begin
        word = '{bbtc_pkg::OP_BEAT_UPD, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_LOAD_BAR: begin
        word = '{bbtc_pkg::OP_LOAD_BAR, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_DIV_BAR: begin
        word = '{bbtc_pkg::OP_DIV_STEP, bbtc_pkg::COND_DIV_MORE, bbtc_pkg::ADDR_DIV_BAR, 1'b0};
      end
      bbtc_pkg::ADDR_BAR_UPD: begin
        word = '{bbtc_pkg::OP_BAR_UPD, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_LOAD_Q: begin
        word = '{bbtc_pkg::OP_LOAD_Q, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_DIV_Q: begin
        word = '{bbtc_pkg::OP_DIV_STEP, bbtc_pkg::COND_DIV_MORE, bbtc_pkg::ADDR_DIV_Q, 1'b0};
      end
      bbtc_pkg::ADDR_Q_UPD: begin
        word = '{bbtc_pkg::OP_Q_UPD, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_MUL_LO: begin
        word = '{bbtc_pkg::OP_MUL_LO, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_MUL_HI: begin
        word = '{bbtc_pkg::OP_MUL_HI, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_ACC: begin
        word = '{bbtc_pkg::OP_ACC, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b0};
      end
      bbtc_pkg::ADDR_EMIT: begin
        // hold here while the output register is still occupied
        word = '{bbtc_pkg::OP_EMIT, bbtc_pkg::COND_OUT_FULL, bbtc_pkg::ADDR_EMIT, 1'b1};
      end
      default: begin
        word = '{bbtc_pkg::OP_ACCEPT, bbtc_pkg::COND_NONE, bbtc_pkg::ADDR_WAIT, 1'b1};
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bbtc_seq.sv */
// ----------------------------------------------------------------------------
// bbtc_seq
// step counter with conditional jumps over the control store
// ----------------------------------------------------------------------------
`default_nettype none

module bbtc_seq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire bbtc_pkg::dp_status_t   status,
  output bbtc_pkg::ctl_word_t         ctl
);

  logic [3:0] step;
  logic [3:0] step_next;
  logic       take_jump;

  bbtc_ucode_rom u_rom (
    .addr (step),
    .word (ctl)
  );

  always_comb begin
    case (ctl.cond)
      bbtc_pkg::COND_NO_INPUT: take_jump = !in_valid;
      bbtc_pkg::COND_NOT_ADV:  take_jump = !status.adv_go;
      bbtc_pkg::COND_DIV_MORE: take_jump = status.div_more;
      bbtc_pkg::COND_OUT_FULL: take_jump = status.out_full;
      default:                 take_jump = 1'b0;
    endcase

    if (take_jump) begin
      step_next = ctl.target;
    end else if (ctl.last) begin
      step_next = bbtc_pkg::ADDR_WAIT;
    end else begin
      step_next = step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bbtc_pkg::ADDR_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bbtc_dp.sv */
// ----------------------------------------------------------------------------
// bbtc_dp
// transport datapath: position state, shared divider, multiplier, result register
// ----------------------------------------------------------------------------
`default_nettype none

module bbtc_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bbtc_pkg::ctl_word_t    ctl,
  input  wire logic                   in_valid,
  input  wire logic [2:0]             in_command,
  input  wire logic [15:0]            in_sample_count,
  input  wire logic                   pos_clear,
  input  wire logic [20:0]            len_eff,
  input  wire logic [4:0]             bar_eff,
  input  wire logic [6:0]             q_eff,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output bbtc_pkg::result_t           out_result,
  output bbtc_pkg::dp_status_t        status
);

  // transport state
  logic [20:0] phase;
  logic [31:0] beat;
  logic        playing;

  // latched command
  logic [2:0]  cmd;
  logic [15:0] count;

  // per-transaction work registers
  logic        changed;
  logic        bar_start;
  logic [31:0] bar;
  logic [32:0] base;
  logic [37:0] prod;
  logic [52:0] acc;

  // restoring divider
  logic [20:0] rem;
  logic [31:0] quo;
  logic [20:0] div;
  logic [5:0]  div_cnt;

  logic [21:0] sum;
  logic [21:0] shifted;
  logic [22:0] diff;
  logic [16:0] mul_op;
  logic [37:0] mul_res;
  logic        out_full;

  assign sum     = {1'b0, phase} + {6'd0, count};
  assign shifted = {rem, quo[31]};
  assign diff    = {1'b0, shifted} - {2'd0, div};
  assign mul_op  = (ctl.op == bbtc_pkg::OP_MUL_HI) ? {1'b0, base[32:17]} : base[16:0];
  assign mul_res = {21'd0, mul_op} * {17'd0, len_eff};
  assign out_full = out_valid && !out_ready;

  assign status.adv_go   = (cmd == bbtc_pkg::CMD_ADVANCE) && playing;
  assign status.div_more = (div_cnt != 6'd1);
  assign status.out_full = out_full;

  // position and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      beat    <= '0;
      playing <= 1'b0;
    end else if (pos_clear) begin
      phase <= '0;
      beat  <= '0;
    end else if (ctl.op == bbtc_pkg::OP_CMD) begin
      case (cmd)
        bbtc_pkg::CMD_PLAY: begin
          playing <= 1'b1;
        end
        bbtc_pkg::CMD_PAUSE: begin
          playing <= 1'b0;
        end
        bbtc_pkg::CMD_STOP: begin
          playing <= 1'b0;
          phase   <= '0;
          beat    <= '0;
        end
        bbtc_pkg::CMD_REWIND: begin
          phase <= '0;
          beat  <= '0;
        end
        default: begin
        end
      endcase
    end else if (ctl.op == bbtc_pkg::OP_BEAT_UPD) begin
      phase <= rem;
      beat  <= beat + quo;
    end
  end

  // work registers, one operation per step
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bbtc_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          cmd   <= in_command;
          count <= in_sample_count;
        end
      end
      bbtc_pkg::OP_CMD: begin
        changed <= 1'b0;
        rem     <= '0;
        quo     <= {sum, 10'd0};
        div     <= len_eff;
        div_cnt <= bbtc_pkg::DIV_SUM_STEPS;
      end
      bbtc_pkg::OP_DIV_STEP: begin
        if (!diff[22]) begin
          rem <= diff[20:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[20:0];
          quo <= {quo[30:0], 1'b0};
        end
        div_cnt <= div_cnt - 6'd1;
      end
      bbtc_pkg::OP_BEAT_UPD: begin
        changed <= (quo != '0);
      end
      bbtc_pkg::OP_LOAD_BAR: begin
        rem     <= '0;
        quo     <= beat;
        div     <= {16'd0, bar_eff};
        div_cnt <= bbtc_pkg::DIV_WORD_STEPS;
      end
      bbtc_pkg::OP_BAR_UPD: begin
        bar       <= quo;
        bar_start <= changed && (rem == '0);
      end
      bbtc_pkg::OP_LOAD_Q: begin
        rem     <= '0;
        quo     <= beat;
        div     <= {14'd0, q_eff};
        div_cnt <= bbtc_pkg::DIV_WORD_STEPS;
      end
      bbtc_pkg::OP_Q_UPD: begin
        base <= {1'b0, beat - {11'd0, rem}} + {26'd0, q_eff};
      end
      bbtc_pkg::OP_MUL_LO: begin
        prod <= mul_res;
      end
      bbtc_pkg::OP_MUL_HI: begin
        acc  <= {15'd0, prod};
        prod <= mul_res;
      end
      bbtc_pkg::OP_ACC: begin
        acc <= acc + {prod[35:0], 17'd0};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.op == bbtc_pkg::OP_EMIT) && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == bbtc_pkg::OP_EMIT) && !out_full) begin
      out_result.next_quantized_sample <= acc;
      out_result.is_playing            <= playing;
      out_result.beat_phase            <= phase;
      out_result.bar_now               <= bar;
      out_result.beat_now              <= beat;
      out_result.bar_started           <= bar_start;
      out_result.beat_changed          <= changed;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the beat and bar transport clock
// ----------------------------------------------------------------------------
// Transport commands go in on the command stream and results come back on the
// result stream. A scoreboard class keeps its own copy of the transport state
// and the three registers, predicts one result per accepted command and checks
// every result field by field in order. A directed opener comes first, then
// random phases under several register settings and idling modes, including a
// long output hold-off and a full drain in the middle of a phase.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_PERIOD  = 10;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_PHASES    = 8;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int SETTLE_CYCLES    = 8;
  localparam int END_CYCLES       = 120;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int MAX_REPORTS      = 40;

  // codes the block has no meaning for, and an index past the register list
  localparam logic [2:0] CMD_FIRST_UNUSED = bbtc_pkg::CMD_REWIND + 3'd1;
  localparam logic [2:0] CMD_LAST_CODE    = 3'd7;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // --------------------------------------------------------------------------
  // transport tracker: predicts each result and checks the block against it
  // --------------------------------------------------------------------------
  class beat_clock_scoreboard;
    logic [20:0]       beat_length;
    logic [4:0]        beats_per_bar;
    logic [6:0]        beats_per_quantum;
    logic [20:0]       phase;
    logic [31:0]       beat;
    bit                playing;
    bbtc_pkg::result_t expected_results[$];
    int                errors;
    int                commands_noted;
    int                results_checked;
    int                beat_changes;
    int                bar_starts;

    function new();
      beat_length       = bbtc_pkg::BEAT_LENGTH_RST;
      beats_per_bar     = bbtc_pkg::BEATS_PER_BAR_RST;
      beats_per_quantum = bbtc_pkg::BEATS_PER_QUANTUM_RST;
      playing           = 1'b0;
      clear_position();
    endfunction

    function void clear_position();
      phase = '0;
      beat  = '0;
    endfunction

    function void write_register(logic [1:0] index, logic [20:0] data);
      case (index)
        bbtc_pkg::REG_BEAT_LENGTH: begin
          // a tempo change restarts the timeline
          beat_length = data;
          clear_position();
        end
        bbtc_pkg::REG_BEATS_PER_BAR:     beats_per_bar = data[4:0];
        bbtc_pkg::REG_BEATS_PER_QUANTUM: beats_per_quantum = data[6:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [2:0] cmd, logic [15:0] count);
      bbtc_pkg::result_t want;
      logic [31:0]       len;
      logic [31:0]       bars;
      logic [31:0]       quantum;
      logic [31:0]       sum;
      logic [31:0]       whole_beats;
      logic [31:0]       beat_in_quantum;
      logic [63:0]       boundary;
      bit                changed;
      changed = 1'b0;
      len = (beat_length == 0) ? 32'd1 : 32'(beat_length);
      bars = (beats_per_bar == 0) ? 32'd1 :
             (beats_per_bar > 16) ? 32'd16 : 32'(beats_per_bar);
      quantum = (beats_per_quantum == 0) ? 32'd1 :
                (beats_per_quantum > 64) ? 32'd64 : 32'(beats_per_quantum);
      case (cmd)
        bbtc_pkg::CMD_ADVANCE: begin
          // paused transport keeps its position
          if (playing) begin
            sum = 32'(phase) + 32'(count);
            whole_beats = sum / len;
            phase = 21'(sum % len);
            if (whole_beats != 0) begin
              beat = beat + whole_beats;
              changed = 1'b1;
            end
          end
        end
        bbtc_pkg::CMD_PLAY:  playing = 1'b1;
        bbtc_pkg::CMD_PAUSE: playing = 1'b0;
        bbtc_pkg::CMD_STOP: begin
          playing = 1'b0;
          clear_position();
        end
        bbtc_pkg::CMD_REWIND: clear_position();
        default: ;
      endcase
      beat_in_quantum = beat % quantum;
      boundary = (64'(beat - beat_in_quantum) + 64'(quantum)) * 64'(len);
      want.beat_changed          = changed;
      want.bar_started           = changed && (beat % bars == 0);
      want.beat_now              = beat;
      want.bar_now               = beat / bars;
      want.beat_phase            = phase;
      want.is_playing            = playing;
      want.next_quantized_sample = boundary[52:0];
      expected_results.push_back(want);
      commands_noted++;
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [143:0] word);
      bbtc_pkg::result_t want;
      bbtc_pkg::result_t got;
      got = bbtc_pkg::result_t'(word[140:0]);
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no command pending expected none actual %h",
                   $time, word);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (want.beat_changed) beat_changes++;
      if (want.bar_started) bar_starts++;
      compare("beat_changed", want.beat_changed, got.beat_changed);
      compare("bar_started", want.bar_started, got.bar_started);
      compare("beat_now", want.beat_now, got.beat_now);
      compare("bar_now", want.bar_now, got.bar_now);
      compare("beat_phase", want.beat_phase, got.beat_phase);
      compare("is_playing", want.is_playing, got.is_playing);
      compare("next_quantized_sample", want.next_quantized_sample,
              got.next_quantized_sample);
      compare("tdata padding", 0, word[143:141]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          s_tvalid  = 1'b0;
  logic [15:0]   s_tdata   = '0;
  logic [2:0]    s_tuser   = '0;
  logic          m_tready  = 1'b0;
  logic          cfg_we    = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [20:0]   cfg_data  = '0;
  logic          s_tready;
  logic          m_tvalid;
  logic [143:0]  m_tdata;

  // idling percentages of each side, set per phase
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // long hold-off requests from the stimulus, served by the receiver process
  int hold_requests = 0;
  int holds_started = 0;
  int hold_cycles_left = 0;

  int quiet_cycles = 0;
  int settings_applied = 0;

  beat_clock_scoreboard board = new();

  always #(CLK_HALF_PERIOD) clk = ~clk;

  beat_bar_transport_clock_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [15:0] sample_count
    .s_tuser  (s_tuser),    // [2:0] command
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [0] beat_changed .. [140:88] next_quantized_sample
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // receiver: random stalls, or a long hold-off counted here when asked for
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles_left > 0) begin
      m_tready <= 1'b0;
      hold_cycles_left--;
    end else if (hold_requests != holds_started) begin
      // sender keeps offering meanwhile, so the block backs up into its input
      holds_started++;
      hold_cycles_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: register writes, accepted transactions on both sides, watchdog
  // all signals read here hold their values from before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) board.note_command(s_tuser, s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus tasks
  // --------------------------------------------------------------------------

  // offer one command and hold it until the block takes it
  task automatic send_command(logic [2:0] cmd, logic [15:0] count);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= count;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 48; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 48; end
      IDLE_BOTH:     begin sender_idle_pct = 14; stall_pct = 14; end
      default: ;
    endcase
  endtask

  // registers only change with the block idle; the unused index goes too
  task automatic apply_setting(logic [20:0] len_word, logic [20:0] bar_word,
                               logic [20:0] quantum_word);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= bbtc_pkg::REG_BEAT_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_index <= bbtc_pkg::REG_BEATS_PER_BAR;
    cfg_data  <= bar_word;
    @(posedge clk);
    cfg_index <= bbtc_pkg::REG_BEATS_PER_QUANTUM;
    cfg_data  <= quantum_word;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 21'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  // block sizes: mostly short, with the field extremes and full-range values
  function automatic logic [15:0] random_count();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  // mostly advances on a playing transport, with the other commands mixed in
  task automatic run_random_commands(int count, bit hold_receiver, bit pause_midway);
    logic [2:0] cmd;
    int         pick;
    if (hold_receiver) hold_requests++;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78)      cmd = bbtc_pkg::CMD_ADVANCE;
      else if (pick < 86) cmd = bbtc_pkg::CMD_PLAY;
      else if (pick < 90) cmd = bbtc_pkg::CMD_PAUSE;
      else if (pick < 93) cmd = bbtc_pkg::CMD_STOP;
      else if (pick < 96) cmd = bbtc_pkg::CMD_REWIND;
      else                cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
      send_command(cmd, random_count());
      if (pause_midway && n == count / 2) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opener at the reset settings (22050 samples per beat, 4 and 4)
    set_idling(IDLE_NONE);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd1000);   // advance while stopped
    send_command(bbtc_pkg::CMD_PLAY, 16'd0);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd0);      // empty block
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd22049);  // one short of the boundary
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd1);      // lands exactly on beat one
    send_command(bbtc_pkg::CMD_ADVANCE, 16'hFFFF);   // crosses two beats
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd22050);  // reaches beat four, a bar start
    send_command(bbtc_pkg::CMD_PAUSE, 16'hFFFF);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'hFFFF);   // paused, nothing moves
    send_command(CMD_FIRST_UNUSED, 16'h5A5A);        // unknown codes are ignored
    send_command(CMD_FIRST_UNUSED + 3'd1, 16'hA5A5);
    send_command(CMD_LAST_CODE, 16'hFFFF);
    send_command(bbtc_pkg::CMD_PLAY, 16'd0);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd30000);
    send_command(bbtc_pkg::CMD_REWIND, 16'd0);       // position cleared, still playing
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd44100);
    send_command(bbtc_pkg::CMD_STOP, 16'd0);         // position cleared, stopped
    send_command(bbtc_pkg::CMD_ADVANCE, 16'd500);
    send_command(bbtc_pkg::CMD_PLAY, 16'd0);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'hFFFF);
    send_command(bbtc_pkg::CMD_ADVANCE, 16'hFFFF);
    send_command(bbtc_pkg::CMD_PLAY, 16'd0);         // play while already playing

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      logic [20:0] len_word;
      logic [20:0] bar_word;
      logic [20:0] quantum_word;
      // unused upper bits of the write data carry random values
      len_word     = 21'($urandom);
      bar_word     = 21'($urandom);
      quantum_word = 21'($urandom);
      case (p)
        0: begin  // smallest legal settings, every sample a beat
          len_word = 21'd1;
          bar_word[4:0] = 5'd1;
          quantum_word[6:0] = 7'd1;
        end
        1: begin  // largest legal settings
          len_word = '1;
          bar_word[4:0] = 5'd16;
          quantum_word[6:0] = 7'd64;
        end
        2: begin  // zeros fall back to one
          len_word = '0;
          bar_word[4:0] = 5'd0;
          quantum_word[6:0] = 7'd0;
        end
        3: begin  // out-of-range bar and quantum saturate
          len_word = 21'($urandom_range(1, 3000));
          bar_word[4:0] = '1;
          quantum_word[6:0] = '1;
        end
        default: begin
          len_word = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(3001, 200000))
                                                 : 21'($urandom_range(1, 3000));
          bar_word[4:0] = 5'($urandom_range(1, 16));
          quantum_word[6:0] = 7'($urandom_range(1, 64));
        end
      endcase
      apply_setting(len_word, bar_word, quantum_word);
      set_idling(idle_mode_t'(p % 4));
      // start playing so the phase does not open on a stopped transport
      send_command(bbtc_pkg::CMD_PLAY, random_count());
      run_random_commands(RANDOM_PER_PHASE, p == 1, p == 2);
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);

    $display("tb_top: %0d commands, %0d results checked, %0d beat changes, %0d bar starts",
             board.commands_noted, board.results_checked, board.beat_changes,
             board.bar_starts);
    $display("tb_top: %0d register settings incl. zero and saturating values, four idling modes",
             settings_applied);
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bbtc_pkg.sv
hw/rtl/bbtc_ucode_rom.sv
hw/rtl/bbtc_seq.sv
hw/rtl/bbtc_dp.sv
hw/rtl/beat_bar_transport_clock_top.sv
bench/tb_top.sv
